// File: rtl/hexacopter_mixer_with_auto_throttle_macros.svh
// ----------------------------------------------------------------------------
// Hexacopter mixer assertion macros
// Concurrent assertion wrappers used by the top level of the motor mixer.
// ----------------------------------------------------------------------------
`ifndef HEXACOPTER_MIXER_WITH_AUTO_THROTTLE_MACROS_SVH
`define HEXACOPTER_MIXER_WITH_AUTO_THROTTLE_MACROS_SVH

`ifndef ASSERT_OFF

`define HMX_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HMX_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define HMX_ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define HMX_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/hmx_pkg.sv
// ----------------------------------------------------------------------------
// Hexacopter mixer package
// Types, constants and register map shared by the motor mixer modules.
// ----------------------------------------------------------------------------
package hmx_pkg;

    localparam int THR_W       = 12;
    localparam int TERM_W      = 12;
    localparam int MOTOR_W     = 12;
    localparam int MAX_THR_W   = 12;
    localparam int MIN_THR_W   = 11;
    localparam int STICK_MIN_W = 11;
    localparam int SEQ_CNT_W   = 11;
    localparam int MIX_W       = 15;
    localparam int LIM_W       = MIX_W + 1;
    localparam int NUM_MOTORS  = 6;

    localparam int COEF_FRAC_BITS_DEF = 10;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_MAX_THROTTLE    = 2'd0;
    localparam logic [1:0] REG_MIN_THROTTLE    = 2'd1;
    localparam logic [1:0] REG_STICK_MIN_CHECK = 2'd2;

    localparam logic [MAX_THR_W-1:0]   MAX_THROTTLE_RST    = 12'd2000;
    localparam logic [MIN_THR_W-1:0]   MIN_THROTTLE_RST    = 11'd1100;
    localparam logic [STICK_MIN_W-1:0] STICK_MIN_CHECK_RST = 11'd1100;

    localparam int SEQ_HOLD_TICKS = 500;
    localparam int SEQ_END_TICK   = 1050;
    localparam int SEQ_STEP_TICKS = 50;
    localparam int SEQ_STEP_SIZE  = 20;
    localparam int SEQ_HOLD_THR   = 1520;
    localparam int SEQ_START_THR  = 1500;
    localparam int SEQ_FLOOR_THR  = 1400;
    localparam int SEQ_NUM_STEPS  = (SEQ_START_THR - SEQ_FLOOR_THR) / SEQ_STEP_SIZE;
    localparam int AUX_LOW        = 1400;
    localparam int AUX_HIGH       = 1600;
    localparam int IDLE_PWM       = 1000;

    typedef struct packed {
        logic [THR_W-1:0]         throttle_cmd;
        logic signed [TERM_W-1:0] roll_term;
        logic signed [TERM_W-1:0] pitch_term;
        logic signed [TERM_W-1:0] yaw_term;
        logic [THR_W-1:0]         aux_switch;
        logic [THR_W-1:0]         stick_throttle;
        logic                     armed;
        logic                     alt_hold;
    } hmx_tick_t;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_front_a;
        logic [MOTOR_W-1:0] motor_rear_a;
        logic [MOTOR_W-1:0] motor_front_b;
        logic [MOTOR_W-1:0] motor_rear_b;
        logic [MOTOR_W-1:0] motor_side_a;
        logic [MOTOR_W-1:0] motor_side_b;
    } hmx_motors_t;

    typedef struct packed {
        logic [MAX_THR_W-1:0]   max_throttle;
        logic [MIN_THR_W-1:0]   min_throttle;
        logic [STICK_MIN_W-1:0] stick_min_check;
    } hmx_cfg_t;

    typedef struct packed {
        logic [THR_W-1:0]         thr;
        logic signed [TERM_W-1:0] roll;
        logic signed [TERM_W-1:0] pitch;
        logic signed [TERM_W-1:0] yaw;
        logic                     force_idle;
    } hmx_stage1_t;

    typedef struct packed {
        logic signed [NUM_MOTORS-1:0][MIX_W-1:0] mix;
        logic                                    force_idle;
    } hmx_stage2_t;

    typedef struct packed {
        logic [SEQ_CNT_W-1:0] count;
        logic                 active;
        logic                 used;
    } hmx_seq_status_t;

    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } hmx_pipe_ctrl_t;

endpackage

// File: rtl/hmx_stream_if.sv
// ----------------------------------------------------------------------------
// Hexacopter mixer stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface hmx_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// File: rtl/hmx_regs.sv
// ----------------------------------------------------------------------------
// Hexacopter mixer configuration registers
// APB-style register file holding the throttle limits and stick threshold.
// ----------------------------------------------------------------------------
module hmx_regs
    import hmx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output hmx_cfg_t              cfg
);

    hmx_cfg_t   cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_throttle    <= MAX_THROTTLE_RST;
            cfg_reg.min_throttle    <= MIN_THROTTLE_RST;
            cfg_reg.stick_min_check <= STICK_MIN_CHECK_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_MAX_THROTTLE:
                begin
                    cfg_reg.max_throttle <= pwdata[MAX_THR_W-1:0];
                end
                REG_MIN_THROTTLE:
                begin
                    cfg_reg.min_throttle <= pwdata[MIN_THR_W-1:0];
                end
                REG_STICK_MIN_CHECK:
                begin
                    cfg_reg.stick_min_check <= pwdata[STICK_MIN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MAX_THROTTLE:    prdata = APB_DATA_W'(cfg_reg.max_throttle);
            REG_MIN_THROTTLE:    prdata = APB_DATA_W'(cfg_reg.min_throttle);
            REG_STICK_MIN_CHECK: prdata = APB_DATA_W'(cfg_reg.stick_min_check);
            default:             prdata = '0;
        endcase
    end

endmodule

// File: rtl/hmx_seq.sv
// ----------------------------------------------------------------------------
// Hexacopter mixer take-off sequencer
// Runs the one-shot take-off throttle profile and registers the tick.
// ----------------------------------------------------------------------------
module hmx_seq
    import hmx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  hmx_tick_t              tick_data,
    input  logic [STICK_MIN_W-1:0] stick_min_check,
    output hmx_stage1_t            stage1,
    output hmx_seq_status_t        status
);

    logic [SEQ_CNT_W-1:0] count_reg;
    logic [SEQ_CNT_W-1:0] count_next;
    logic                 active_reg;
    logic                 active_next;
    logic                 used_reg;
    logic                 used_next;
    logic [SEQ_CNT_W-1:0] count_inc;
    logic [THR_W-1:0]     step_thr;
    logic [THR_W-1:0]     thr;
    logic                 trigger;
    logic                 stick_low;
    hmx_stage1_t          stage1_reg;
    hmx_stage1_t          stage1_next;

    assign count_inc = count_reg + SEQ_CNT_W'(1);
    assign trigger   = (tick_data.aux_switch > THR_W'(AUX_LOW)) &&
                       (tick_data.aux_switch < THR_W'(AUX_HIGH)) && !used_reg;
    assign stick_low = tick_data.stick_throttle < THR_W'(stick_min_check);

    always_comb
    begin
        step_thr = THR_W'(SEQ_START_THR);
        for (int k = 1; k <= SEQ_NUM_STEPS; k++)
        begin
            if (count_inc >= SEQ_CNT_W'(SEQ_HOLD_TICKS + SEQ_STEP_TICKS * k))
            begin
                step_thr = THR_W'(SEQ_START_THR - SEQ_STEP_SIZE * k);
            end
        end
    end

    always_comb
    begin
        used_next   = used_reg || trigger;
        active_next = active_reg || trigger;
        count_next  = count_reg;
        thr         = tick_data.throttle_cmd;
        if (active_next)
        begin
            count_next = count_inc;
            if (count_reg < SEQ_CNT_W'(SEQ_HOLD_TICKS))
            begin
                thr = THR_W'(SEQ_HOLD_THR);
            end
            else if (count_reg <= SEQ_CNT_W'(SEQ_END_TICK))
            begin
                thr = step_thr;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        stage1_next.thr        = thr;
        stage1_next.roll       = tick_data.roll_term;
        stage1_next.pitch      = tick_data.pitch_term;
        stage1_next.yaw        = tick_data.yaw_term;
        stage1_next.force_idle = !tick_data.armed ||
                                 (!tick_data.alt_hold && stick_low && !active_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            active_reg <= 1'b0;
            used_reg   <= 1'b0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            active_reg <= active_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage1_reg <= stage1_next;
        end
    end

    assign stage1        = stage1_reg;
    assign status.count  = count_reg;
    assign status.active = active_reg;
    assign status.used   = used_reg;

endmodule

// File: rtl/hmx_mix.sv
// ----------------------------------------------------------------------------
// Hexacopter mixer hex-X mixing stage
// Forms the six motor mixes; the four fixed-point ones are truncated toward zero.
// ----------------------------------------------------------------------------
module hmx_mix
    import hmx_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        load,
    input  hmx_stage1_t stage1,
    output hmx_stage2_t stage2
);

    localparam int SUM_W = MIX_W + COEF_FRAC_BITS + 2;
    localparam logic signed [SUM_W-1:0] COEF_HALF = SUM_W'(1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] COEF_866  =
        SUM_W'(((866 << COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << COEF_FRAC_BITS) - 1);

    logic signed [SUM_W-1:0] thr_e;
    logic signed [SUM_W-1:0] roll_e;
    logic signed [SUM_W-1:0] pitch_e;
    logic signed [SUM_W-1:0] yaw_e;
    logic signed [SUM_W-1:0] base_a;
    logic signed [SUM_W-1:0] base_b;
    logic signed [SUM_W-1:0] roll_half;
    logic signed [SUM_W-1:0] pitch_866;
    hmx_stage2_t             stage2_reg;
    hmx_stage2_t             stage2_next;

    function automatic logic signed [MIX_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] adj;
        adj = s + (s[SUM_W-1] ? TRUNC_BIAS : SUM_W'(0));
        return MIX_W'(adj >>> COEF_FRAC_BITS);
    endfunction

    assign thr_e     = SUM_W'($signed({1'b0, stage1.thr}));
    assign roll_e    = SUM_W'(stage1.roll);
    assign pitch_e   = SUM_W'(stage1.pitch);
    assign yaw_e     = SUM_W'(stage1.yaw);
    assign base_a    = (thr_e - yaw_e) <<< COEF_FRAC_BITS;
    assign base_b    = (thr_e + yaw_e) <<< COEF_FRAC_BITS;
    assign roll_half = roll_e * COEF_HALF;
    assign pitch_866 = pitch_e * COEF_866;

    always_comb
    begin
        stage2_next.mix[0]     = trunc_frac(base_a + roll_half + pitch_866);
        stage2_next.mix[1]     = trunc_frac(base_b - roll_half - pitch_866);
        stage2_next.mix[2]     = trunc_frac(base_b - roll_half + pitch_866);
        stage2_next.mix[3]     = trunc_frac(base_a + roll_half - pitch_866);
        stage2_next.mix[4]     = MIX_W'(thr_e + roll_e + yaw_e);
        stage2_next.mix[5]     = MIX_W'(thr_e - roll_e - yaw_e);
        stage2_next.force_idle = stage1.force_idle;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage2_reg <= stage2_next;
        end
    end

    assign stage2 = stage2_reg;

endmodule

// File: rtl/hmx_limit.sv
// ----------------------------------------------------------------------------
// Hexacopter mixer limiting stage
// Shifts the mixes under the ceiling, clamps them and applies motor idle.
// ----------------------------------------------------------------------------
module hmx_limit
    import hmx_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  hmx_stage2_t stage2,
    input  hmx_cfg_t    cfg,
    output hmx_motors_t motors
);

    logic signed [LIM_W-1:0]                  lo;
    logic signed [LIM_W-1:0]                  hi;
    logic signed [LIM_W-1:0]                  max01;
    logic signed [LIM_W-1:0]                  max23;
    logic signed [LIM_W-1:0]                  max45;
    logic signed [LIM_W-1:0]                  max03;
    logic signed [LIM_W-1:0]                  top;
    logic signed [LIM_W-1:0]                  excess;
    logic signed [LIM_W-1:0]                  shifted [NUM_MOTORS];
    logic [NUM_MOTORS-1:0][MOTOR_W-1:0]       pwm;
    hmx_motors_t                              motors_reg;
    hmx_motors_t                              motors_next;

    function automatic logic signed [LIM_W-1:0] smax(input logic signed [LIM_W-1:0] a,
                                                     input logic signed [LIM_W-1:0] b);
        return (b > a) ? b : a;
    endfunction

    assign lo     = LIM_W'($signed({1'b0, cfg.min_throttle}));
    assign hi     = LIM_W'($signed({1'b0, cfg.max_throttle}));
    assign max01  = smax(LIM_W'($signed(stage2.mix[0])), LIM_W'($signed(stage2.mix[1])));
    assign max23  = smax(LIM_W'($signed(stage2.mix[2])), LIM_W'($signed(stage2.mix[3])));
    assign max45  = smax(LIM_W'($signed(stage2.mix[4])), LIM_W'($signed(stage2.mix[5])));
    assign max03  = smax(max01, max23);
    assign top    = smax(max03, max45);
    assign excess = (top > hi) ? (top - hi) : LIM_W'(0);

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            shifted[i] = LIM_W'($signed(stage2.mix[i])) - excess;
            if (stage2.force_idle)
            begin
                pwm[i] = MOTOR_W'(IDLE_PWM);
            end
            else if (shifted[i] < lo)
            begin
                pwm[i] = lo[MOTOR_W-1:0];
            end
            else if (shifted[i] > hi)
            begin
                pwm[i] = hi[MOTOR_W-1:0];
            end
            else
            begin
                pwm[i] = shifted[i][MOTOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        motors_next.motor_front_a = pwm[0];
        motors_next.motor_rear_a  = pwm[1];
        motors_next.motor_front_b = pwm[2];
        motors_next.motor_rear_b  = pwm[3];
        motors_next.motor_side_a  = pwm[4];
        motors_next.motor_side_b  = pwm[5];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            motors_reg <= motors_next;
        end
    end

    assign motors = motors_reg;

endmodule

// File: rtl/hexacopter_mixer_with_auto_throttle.sv
// ----------------------------------------------------------------------------
// Hexacopter X motor mixer with automatic take-off throttle
// An accepted tick beat passes the sequencer, mix and limit registers to its motor beat.
// Throughput is one tick per cycle while motors.ready is not stalling, set by the three-register pipeline.
// Reset clears the sequencer state and the pipeline valid flags and restores the register defaults.
// ----------------------------------------------------------------------------
`include "hexacopter_mixer_with_auto_throttle_macros.svh"

module hexacopter_mixer_with_auto_throttle
    import hmx_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hmx_stream_if.sink            tick,
    hmx_stream_if.source          motors,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    hmx_cfg_t        cfg;
    hmx_stage1_t     stage1;
    hmx_stage2_t     stage2;
    hmx_motors_t     motors_data;
    hmx_seq_status_t seq_status;
    hmx_pipe_ctrl_t  ctrl;
    logic            en1;
    logic            en2;
    logic            en3;
    logic            v1_reg;
    logic            v2_reg;
    logic            v3_reg;
    logic            accept;

    assign en3    = !v3_reg || motors.ready;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = tick.valid && en1;

    assign ctrl.load1 = accept;
    assign ctrl.load2 = en2 && v1_reg;
    assign ctrl.load3 = en3 && v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= tick.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    hmx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hmx_seq u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (ctrl.load1),
        .tick_data       (tick.payload),
        .stick_min_check (cfg.stick_min_check),
        .stage1          (stage1),
        .status          (seq_status)
    );

    hmx_mix #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mix (
        .clk    (clk),
        .load   (ctrl.load2),
        .stage1 (stage1),
        .stage2 (stage2)
    );

    hmx_limit u_limit (
        .clk    (clk),
        .load   (ctrl.load3),
        .stage2 (stage2),
        .cfg    (cfg),
        .motors (motors_data)
    );

    assign tick.ready     = en1;
    assign motors.valid   = v3_reg;
    assign motors.payload = motors_data;

    `HMX_ASSERT_NEVER(a_seq_one_shot, clk, rst_n, seq_status.active && !seq_status.used, "take-off sequence active without having been started")

    `HMX_ASSERT_PROP(a_seq_count_step, clk, rst_n, (accept && seq_status.active) |=> (seq_status.count == $past(seq_status.count) + 11'd1), "sequence count did not advance on an active tick")

    `HMX_ASSERT_PROP(a_stall_full, clk, rst_n, !tick.ready |-> (v1_reg && v2_reg && v3_reg && !motors.ready), "tick stalled while the pipeline has room")

endmodule
